/* hdl/ifrc_pkg.sv */
package ifrc_pkg;

    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int ADDR_W    = 32;
    localparam int TOTAL_W   = 64;

    typedef logic [1:0] t_cmd_code;
    localparam t_cmd_code CMD_LOAD_LOCAL = 2'd0;
    localparam t_cmd_code CMD_LOAD_OTHER = 2'd1;
    localparam t_cmd_code CMD_RECORD     = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LOCAL_COUNT = 1'b0;
    localparam t_cfg_idx CFG_OTHER_COUNT = 1'b1;

    typedef logic [1:0] t_cls;
    localparam t_cls CLS_LOCAL  = 2'd0;
    localparam t_cls CLS_OTHER  = 2'd1;
    localparam t_cls CLS_REMOTE = 2'd2;
    localparam t_cls CLS_NONE   = 2'd3;

    typedef logic [2:0] t_cat;
    localparam t_cat CAT_LOCAL_REMOTE = 3'd0;
    localparam t_cat CAT_REMOTE_LOCAL = 3'd1;
    localparam t_cat CAT_INTERNAL     = 3'd2;
    localparam t_cat CAT_EXTERNAL     = 3'd3;
    localparam t_cat CAT_OTHER        = 3'd4;
    localparam t_cat CAT_NONE         = 3'd5;

    typedef struct packed {
        t_cmd_code           command;
        logic [2:0]          entry_index;
        logic [ADDR_W-1:0]   range_low;
        logic [ADDR_W-1:0]   range_high;
        logic [ADDR_W-1:0]   first_addr;
        logic [ADDR_W-1:0]   second_addr;
        logic [31:0]         in_bytes;
        logic [31:0]         out_bytes;
        logic [31:0]         in_packets;
        logic [31:0]         out_packets;
    } t_ifrc_in;

    typedef struct packed {
        t_cls                first_code;
        t_cls                second_code;
        t_cat                category;
        logic [TOTAL_W-1:0]  connections;
        logic [TOTAL_W-1:0]  packets;
        logic [TOTAL_W-1:0]  bytes;
        logic [TOTAL_W-1:0]  incoming;
        logic [TOTAL_W-1:0]  outgoing;
        logic [TOTAL_W-1:0]  internal;
        logic [TOTAL_W-1:0]  external;
        logic [TOTAL_W-1:0]  other_bytes;
    } t_ifrc_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LWALK,
        ST_OWALK,
        ST_FINISH
    } t_ifrc_state;

    typedef struct packed {
        logic             capture;
        logic             write_table;
        logic             clear_hits;
        logic             rd_local;
        logic             rd_other;
        logic [CNT_W-1:0] rd_addr;
        logic             push;
    } t_ifrc_cmd;

    typedef struct packed {
        logic             is_record;
        logic [CNT_W-1:0] local_len;
        logic [CNT_W-1:0] other_len;
        logic             out_free;
    } t_ifrc_stat;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                    input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage

/* hdl/ipv4_flow_range_classifier_unit.sv */
// A flow record walks Nl local and then No other table entries before its result is given, where
// Nl and No are the local and other range counts clipped to the table depths; the range
// walk reads one table entry per cycle and checks both addresses against it.
// A load or unused command skips the walk and goes straight to its result.
// A new item is taken only after the last result is registered; a stalled result delays the next.
// Reset (synchronous, active low) clears totals, range counts and control; tables stay as is.
module ipv4_flow_range_classifier_unit #(
    parameter int LOCAL_RANGES = 8,
    parameter int OTHER_RANGES = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  ifrc_pkg::t_ifrc_in     i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output ifrc_pkg::t_ifrc_out    o_out_data,
    input  logic                   i_cfg_we,
    input  ifrc_pkg::t_cfg_idx     i_cfg_index,
    input  logic [ifrc_pkg::CNT_W-1:0] i_cfg_data
);
    import ifrc_pkg::*;

    t_ifrc_cmd  cmd;
    t_ifrc_stat stat;

    ifrc_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ifrc_dp #(
        .LOCAL_RANGES (LOCAL_RANGES),
        .OTHER_RANGES (OTHER_RANGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* hdl/ifrc_ctl.sv */
module ifrc_ctl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  ifrc_pkg::t_ifrc_stat   i_stat,
    output ifrc_pkg::t_ifrc_cmd    o_cmd
);
    import ifrc_pkg::*;

    t_ifrc_state      r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and walk counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                n_cnt   = '0;
                n_state = i_stat.is_record ? ST_LWALK : ST_FINISH;
            end
            ST_LWALK: begin
                if (r_cnt < i_stat.local_len) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_cnt   = '0;
                    n_state = ST_OWALK;
                end
            end
            ST_OWALK: begin
                // the cycle after the last read lets its compare land
                if (r_cnt < i_stat.other_len) n_cnt = r_cnt + 1'b1;
                else n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready          = 1'b0;
        o_cmd               = '0;
        o_cmd.rd_addr       = r_cnt;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_DECODE: begin
                o_cmd.write_table = 1'b1;
                o_cmd.clear_hits  = 1'b1;
            end
            ST_LWALK:  o_cmd.rd_local = (r_cnt < i_stat.local_len);
            ST_OWALK:  o_cmd.rd_other = (r_cnt < i_stat.other_len);
            ST_FINISH: o_cmd.push     = i_stat.out_free;
            default:   o_cmd          = '0;
        endcase
    end

endmodule

/* hdl/ifrc_dp.sv */
module ifrc_dp #(
    parameter int LOCAL_RANGES = 8,
    parameter int OTHER_RANGES = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ifrc_pkg::t_ifrc_in     i_in_data,
    input  logic                   i_cfg_we,
    input  ifrc_pkg::t_cfg_idx     i_cfg_index,
    input  logic [ifrc_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                   i_out_ready,
    input  ifrc_pkg::t_ifrc_cmd    i_cmd,
    output ifrc_pkg::t_ifrc_stat   o_stat,
    output logic                   o_out_valid,
    output ifrc_pkg::t_ifrc_out    o_out_data
);
    import ifrc_pkg::*;

    localparam int LAW = (LOCAL_RANGES > 1) ? $clog2(LOCAL_RANGES) : 1;
    localparam int OAW = (OTHER_RANGES > 1) ? $clog2(OTHER_RANGES) : 1;

    // {high, low} per entry
    logic [2*ADDR_W-1:0] r_local_mem [LOCAL_RANGES];
    logic [2*ADDR_W-1:0] r_other_mem [OTHER_RANGES];
    logic [2*ADDR_W-1:0] r_local_word, r_other_word;
    logic                r_local_cmp, r_other_cmp;

    t_ifrc_in            r_item;
    logic [CNT_W-1:0]    r_local_count, r_other_count;
    logic                r_hit_l0, r_hit_l1, r_hit_o0, r_hit_o1;

    logic [TOTAL_W-1:0]  r_conn, r_pkts, r_bytes, r_incoming, r_outgoing;
    logic [TOTAL_W-1:0]  r_internal, r_external, r_other;
    logic [TOTAL_W-1:0]  n_conn, n_pkts, n_bytes, n_incoming, n_outgoing;
    logic [TOTAL_W-1:0]  n_internal, n_external, n_other;

    logic                r_out_valid;
    t_ifrc_out           r_out;

    logic                is_record;
    logic [ADDR_W-1:0]   lo_l, hi_l, lo_o, hi_o;
    t_cls                c0, c1;
    t_cat                cat;
    logic [TOTAL_W-1:0]  both_bytes, both_pkts;

    assign is_record = (r_item.command == CMD_RECORD);

    assign o_stat.is_record = is_record;
    assign o_stat.local_len = (32'(r_local_count) > 32'(LOCAL_RANGES)) ?
                              CNT_W'(LOCAL_RANGES) : r_local_count;
    assign o_stat.other_len = (32'(r_other_count) > 32'(OTHER_RANGES)) ?
                              CNT_W'(OTHER_RANGES) : r_other_count;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_count <= '0;
            r_other_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOCAL_COUNT: r_local_count <= i_cfg_data;
                CFG_OTHER_COUNT: r_other_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_in_data;
    end

    // range tables, one read per cycle, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_table && r_item.command == CMD_LOAD_LOCAL &&
            32'(r_item.entry_index) < 32'(LOCAL_RANGES)) begin
            r_local_mem[LAW'(r_item.entry_index)] <= {r_item.range_high, r_item.range_low};
        end
        if (i_cmd.rd_local) r_local_word <= r_local_mem[LAW'(i_cmd.rd_addr)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_table && r_item.command == CMD_LOAD_OTHER &&
            32'(r_item.entry_index) < 32'(OTHER_RANGES)) begin
            r_other_mem[OAW'(r_item.entry_index)] <= {r_item.range_high, r_item.range_low};
        end
        if (i_cmd.rd_other) r_other_word <= r_other_mem[OAW'(i_cmd.rd_addr)];
    end

    assign lo_l = r_local_word[ADDR_W-1:0];
    assign hi_l = r_local_word[2*ADDR_W-1:ADDR_W];
    assign lo_o = r_other_word[ADDR_W-1:0];
    assign hi_o = r_other_word[2*ADDR_W-1:ADDR_W];

    // compare stage: both addresses against the entry read last cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_cmp <= 1'b0;
            r_other_cmp <= 1'b0;
        end else begin
            r_local_cmp <= i_cmd.rd_local;
            r_other_cmp <= i_cmd.rd_other;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_hits) begin
            r_hit_l0 <= 1'b0;
            r_hit_l1 <= 1'b0;
            r_hit_o0 <= 1'b0;
            r_hit_o1 <= 1'b0;
        end else begin
            if (r_local_cmp) begin
                if (r_item.first_addr >= lo_l && r_item.first_addr <= hi_l)
                    r_hit_l0 <= 1'b1;
                if (r_item.second_addr >= lo_l && r_item.second_addr <= hi_l)
                    r_hit_l1 <= 1'b1;
            end
            if (r_other_cmp) begin
                if (r_item.first_addr >= lo_o && r_item.first_addr <= hi_o)
                    r_hit_o0 <= 1'b1;
                if (r_item.second_addr >= lo_o && r_item.second_addr <= hi_o)
                    r_hit_o1 <= 1'b1;
            end
        end
    end

    // classification and accounting
    always_comb begin
        c0 = CLS_NONE;
        c1 = CLS_NONE;
        cat = CAT_NONE;
        both_bytes = TOTAL_W'({1'b0, r_item.in_bytes} + {1'b0, r_item.out_bytes});
        both_pkts  = TOTAL_W'({1'b0, r_item.in_packets} + {1'b0, r_item.out_packets});
        n_conn     = r_conn;
        n_pkts     = r_pkts;
        n_bytes    = r_bytes;
        n_incoming = r_incoming;
        n_outgoing = r_outgoing;
        n_internal = r_internal;
        n_external = r_external;
        n_other    = r_other;
        if (is_record) begin
            if (r_local_count == '0 || r_hit_l0)      c0 = CLS_LOCAL;
            else if (r_other_count != '0 && r_hit_o0) c0 = CLS_OTHER;
            else                                      c0 = CLS_REMOTE;
            if (r_local_count == '0 || r_hit_l1)      c1 = CLS_LOCAL;
            else if (r_other_count != '0 && r_hit_o1) c1 = CLS_OTHER;
            else                                      c1 = CLS_REMOTE;

            n_conn  = sat_add(r_conn, TOTAL_W'(1));
            n_pkts  = sat_add(r_pkts, both_pkts);
            n_bytes = sat_add(r_bytes, both_bytes);
            if (c0 == CLS_LOCAL && c1 == CLS_REMOTE) begin
                cat        = CAT_LOCAL_REMOTE;
                n_incoming = sat_add(r_incoming, TOTAL_W'(r_item.in_bytes));
                n_outgoing = sat_add(r_outgoing, TOTAL_W'(r_item.out_bytes));
            end else if (c0 == CLS_REMOTE && c1 == CLS_LOCAL) begin
                cat        = CAT_REMOTE_LOCAL;
                n_incoming = sat_add(r_incoming, TOTAL_W'(r_item.out_bytes));
                n_outgoing = sat_add(r_outgoing, TOTAL_W'(r_item.in_bytes));
            end else if (c0 == CLS_LOCAL && c1 == CLS_LOCAL) begin
                cat        = CAT_INTERNAL;
                n_internal = sat_add(r_internal, both_bytes);
            end else if (c0 == CLS_REMOTE && c1 == CLS_REMOTE) begin
                cat        = CAT_EXTERNAL;
                n_external = sat_add(r_external, both_bytes);
            end else begin
                cat     = CAT_OTHER;
                n_other = sat_add(r_other, both_bytes);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn     <= '0;
            r_pkts     <= '0;
            r_bytes    <= '0;
            r_incoming <= '0;
            r_outgoing <= '0;
            r_internal <= '0;
            r_external <= '0;
            r_other    <= '0;
        end else if (i_cmd.push) begin
            r_conn     <= n_conn;
            r_pkts     <= n_pkts;
            r_bytes    <= n_bytes;
            r_incoming <= n_incoming;
            r_outgoing <= n_outgoing;
            r_internal <= n_internal;
            r_external <= n_external;
            r_other    <= n_other;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out.first_code  <= c0;
            r_out.second_code <= c1;
            r_out.category    <= cat;
            r_out.connections <= n_conn;
            r_out.packets     <= n_pkts;
            r_out.bytes       <= n_bytes;
            r_out.incoming    <= n_incoming;
            r_out.outgoing    <= n_outgoing;
            r_out.internal    <= n_internal;
            r_out.external    <= n_external;
            r_out.other_bytes <= n_other;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* sim/tb_ipv4_flow_range_classifier_unit.sv */
`timescale 1ns / 1ps

module tb_ipv4_flow_range_classifier_unit;

    import ifrc_pkg::*;

    localparam int TABLE_DEPTH   = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int LIMIT_CYCLES  = 400000;
    localparam t_cmd_code CMD_UNUSED = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_ifrc_in            i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    t_ifrc_out           o_out_data;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_index;
    logic [CNT_W-1:0]    i_cfg_data;

    // mirror of the block's tables, counts and running totals
    logic [31:0]         lcl_lo [TABLE_DEPTH];
    logic [31:0]         lcl_hi [TABLE_DEPTH];
    logic [31:0]         oth_lo [TABLE_DEPTH];
    logic [31:0]         oth_hi [TABLE_DEPTH];
    logic [CNT_W-1:0]    lcl_count;
    logic [CNT_W-1:0]    oth_count;
    t_ifrc_out           run_totals;

    t_ifrc_out           awaited_reports [$];
    t_ifrc_out           oldest_report;
    int                  mismatches = 0;
    int unsigned         cycle_count = 0;
    int                  sender_idle_pct = 0;
    int                  recv_stall_pct = 0;

    ipv4_flow_range_classifier_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
        // a + b wraps exactly when b exceeds the headroom ~a
        if (b > ~a)
            return {64{1'b1}};
        return a + b;
    endfunction

    function automatic logic in_ranges(input logic [31:0] addr, input logic use_other);
        int          n;
        int          i;
        logic        hit;
        logic [31:0] lo;
        logic [31:0] hi;
        n = use_other ? int'(oth_count) : int'(lcl_count);
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        hit = 1'b0;
        for (i = 0; i < n; i++) begin
            lo = use_other ? oth_lo[i] : lcl_lo[i];
            hi = use_other ? oth_hi[i] : lcl_hi[i];
            if (addr >= lo && addr <= hi)
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic t_cls class_of(input logic [31:0] addr);
        if (lcl_count == 0 || in_ranges(addr, 1'b0))
            return CLS_LOCAL;
        if (oth_count != 0 && in_ranges(addr, 1'b1))
            return CLS_OTHER;
        return CLS_REMOTE;
    endfunction

    task automatic account_flow(input t_ifrc_in it);
        t_ifrc_out   rpt;
        t_cls        c0;
        t_cls        c1;
        t_cat        cat;
        logic [63:0] ib;
        logic [63:0] ob;
        logic [63:0] both;
        c0   = CLS_NONE;
        c1   = CLS_NONE;
        cat  = CAT_NONE;
        ib   = {32'b0, it.in_bytes};
        ob   = {32'b0, it.out_bytes};
        both = ib + ob;
        case (it.command)
            CMD_LOAD_LOCAL: begin
                lcl_lo[it.entry_index] = it.range_low;
                lcl_hi[it.entry_index] = it.range_high;
            end
            CMD_LOAD_OTHER: begin
                oth_lo[it.entry_index] = it.range_low;
                oth_hi[it.entry_index] = it.range_high;
            end
            CMD_RECORD: begin
                c0 = class_of(it.first_addr);
                c1 = class_of(it.second_addr);
                run_totals.connections = add_clamped(run_totals.connections, 64'd1);
                run_totals.packets = add_clamped(run_totals.packets,
                    {32'b0, it.in_packets} + {32'b0, it.out_packets});
                run_totals.bytes = add_clamped(run_totals.bytes, both);
                if (c0 == CLS_LOCAL && c1 == CLS_REMOTE) begin
                    cat = CAT_LOCAL_REMOTE;
                    run_totals.incoming = add_clamped(run_totals.incoming, ib);
                    run_totals.outgoing = add_clamped(run_totals.outgoing, ob);
                end else if (c0 == CLS_REMOTE && c1 == CLS_LOCAL) begin
                    cat = CAT_REMOTE_LOCAL;
                    run_totals.incoming = add_clamped(run_totals.incoming, ob);
                    run_totals.outgoing = add_clamped(run_totals.outgoing, ib);
                end else if (c0 == CLS_LOCAL && c1 == CLS_LOCAL) begin
                    cat = CAT_INTERNAL;
                    run_totals.internal = add_clamped(run_totals.internal, both);
                end else if (c0 == CLS_REMOTE && c1 == CLS_REMOTE) begin
                    cat = CAT_EXTERNAL;
                    run_totals.external = add_clamped(run_totals.external, both);
                end else begin
                    cat = CAT_OTHER;
                    run_totals.other_bytes = add_clamped(run_totals.other_bytes, both);
                end
            end
            default: ;
        endcase
        rpt             = run_totals;
        rpt.first_code  = c0;
        rpt.second_code = c1;
        rpt.category    = cat;
        awaited_reports.push_back(rpt);
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_reports.size() == 0) begin
                $error("result transfer with nothing awaited");
                mismatches++;
            end else begin
                oldest_report = awaited_reports.pop_front();
                check_field("first_code", oldest_report.first_code, o_out_data.first_code);
                check_field("second_code", oldest_report.second_code, o_out_data.second_code);
                check_field("category", oldest_report.category, o_out_data.category);
                check_field("connections", oldest_report.connections, o_out_data.connections);
                check_field("packets", oldest_report.packets, o_out_data.packets);
                check_field("bytes", oldest_report.bytes, o_out_data.bytes);
                check_field("incoming", oldest_report.incoming, o_out_data.incoming);
                check_field("outgoing", oldest_report.outgoing, o_out_data.outgoing);
                check_field("internal", oldest_report.internal, o_out_data.internal);
                check_field("external", oldest_report.external, o_out_data.external);
                check_field("other_bytes", oldest_report.other_bytes, o_out_data.other_bytes);
            end
        end
    end

    // called at a falling edge; returns at a falling edge, valid possibly still high
    task automatic send_flow_item(input t_ifrc_in it);
        i_in_valid = 1'b1;
        i_in_data  = it;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        account_flow(it);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (awaited_reports.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_counts(input logic [CNT_W-1:0] lcount, input logic [CNT_W-1:0] ocount);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_LOCAL_COUNT;
        i_cfg_data  = lcount;
        @(negedge i_clk);
        i_cfg_index = CFG_OTHER_COUNT;
        i_cfg_data  = ocount;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        lcl_count   = lcount;
        oth_count   = ocount;
    endtask

    function automatic t_ifrc_in flow_rec(input logic [31:0] a0, input logic [31:0] a1,
                                          input logic [31:0] ib, input logic [31:0] ob,
                                          input logic [31:0] ip, input logic [31:0] op);
        t_ifrc_in it;
        it             = '0;
        it.command     = CMD_RECORD;
        it.first_addr  = a0;
        it.second_addr = a1;
        it.in_bytes    = ib;
        it.out_bytes   = ob;
        it.in_packets  = ip;
        it.out_packets = op;
        return it;
    endfunction

    function automatic t_ifrc_in load_rec(input t_cmd_code cmd, input logic [2:0] idx,
                                          input logic [31:0] lo, input logic [31:0] hi);
        t_ifrc_in it;
        it             = '0;
        it.command     = cmd;
        it.entry_index = idx;
        it.range_low   = lo;
        it.range_high  = hi;
        return it;
    endfunction

    task automatic make_range(output logic [31:0] lo, output logic [31:0] hi);
        lo = $urandom;
        case ($urandom_range(5))
            0: hi = lo + $urandom_range(255);
            1: hi = lo + ($urandom >> 8);
            2: hi = lo;
            3: hi = lo - $urandom_range(1, 1000);     // inverted
            4: begin
                lo = 32'h0;
                hi = $urandom >> 2;
            end
            default: begin
                lo = {2'b11, lo[29:0]};
                hi = 32'hFFFF_FFFF;
            end
        endcase
    endtask

    // addresses clustered on range bounds so all classes show up
    function automatic logic [31:0] pick_addr();
        int          sel;
        int          k;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [63:0] span;
        logic [63:0] off;
        sel = $urandom_range(9);
        k   = $urandom_range(TABLE_DEPTH - 1);
        if (sel >= 7)
            return $urandom;
        if (sel == 6)
            return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
        lo = (sel < 4) ? lcl_lo[k] : oth_lo[k];
        hi = (sel < 4) ? lcl_hi[k] : oth_hi[k];
        case ($urandom_range(4))
            0: return lo;
            1: return hi;
            2: return lo - 32'd1;
            3: return hi + 32'd1;
            default: begin
                if (hi < lo)
                    return lo;
                span = {32'b0, hi} - {32'b0, lo} + 64'd1;
                off  = $urandom;
                off  = off % span;
                return lo + off[31:0];
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_amount();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1500);
            2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    task automatic random_item(output t_ifrc_in it);
        int          pick;
        logic [31:0] lo;
        logic [31:0] hi;
        it.entry_index = $urandom_range(7);
        it.range_low   = $urandom;
        it.range_high  = $urandom;
        it.first_addr  = $urandom;
        it.second_addr = $urandom;
        it.in_bytes    = $urandom;
        it.out_bytes   = $urandom;
        it.in_packets  = $urandom;
        it.out_packets = $urandom;
        pick = $urandom_range(99);
        if (pick < 24) begin
            it.command = (pick < 14) ? CMD_LOAD_LOCAL : CMD_LOAD_OTHER;
            if ($urandom_range(3) != 0) begin
                make_range(lo, hi);
                it.range_low  = lo;
                it.range_high = hi;
            end
        end else if (pick < 28) begin
            it.command = CMD_UNUSED;
        end else begin
            it.command     = CMD_RECORD;
            it.first_addr  = pick_addr();
            it.second_addr = pick_addr();
            it.in_bytes    = pick_amount();
            it.out_bytes   = pick_amount();
            it.in_packets  = pick_amount();
            it.out_packets = pick_amount();
        end
    endtask

    task automatic test_directed_corners();
        // counts still at reset: everything is local
        send_flow_item(flow_rec(32'h0, 32'hFFFF_FFFF, '1, '1, '1, '1));
        send_flow_item(load_rec(CMD_UNUSED, 3'd7, 32'h1234_5678, 32'h9ABC_DEF0));

        send_flow_item(load_rec(CMD_LOAD_LOCAL, 3'd0, 32'h0A00_0000, 32'h0AFF_FFFF));
        send_flow_item(load_rec(CMD_LOAD_LOCAL, 3'd1, 32'h0000_0000, 32'h0000_00FF));
        send_flow_item(load_rec(CMD_LOAD_LOCAL, 3'd2, 32'hFFFF_FF00, 32'hFFFF_FFFF));
        send_flow_item(load_rec(CMD_LOAD_LOCAL, 3'd3, 32'h3000_0010, 32'h3000_0000));
        send_flow_item(load_rec(CMD_LOAD_OTHER, 3'd0, 32'hAC10_0000, 32'hAC1F_FFFF));
        send_flow_item(load_rec(CMD_LOAD_OTHER, 3'd1, 32'h0A00_0000, 32'h0A00_00FF));
        send_flow_item(load_rec(CMD_LOAD_OTHER, 3'd2, 32'hC0A8_0101, 32'hC0A8_0101));
        send_flow_item(load_rec(CMD_LOAD_OTHER, 3'd3, 32'h5000_0001, 32'h5000_0000));
        write_counts(4'd4, 4'd4);

        send_flow_item(flow_rec(32'h0A01_0203, 32'h0808_0808, 1000, 2000, 10, 20));
        send_flow_item(flow_rec(32'h0808_0808, 32'h0A00_0000, 3000, 4000, 30, 40));
        send_flow_item(flow_rec(32'h0000_0000, 32'hFFFF_FFFF, 5, 6, 1, 1));
        // inside inverted ranges: both remote
        send_flow_item(flow_rec(32'h3000_0005, 32'h5000_0000, 7, 8, 2, 3));
        send_flow_item(flow_rec(32'h0AFF_FFFF, 32'hAC10_0000, 9, 10, 4, 5));
        send_flow_item(flow_rec(32'hAC1F_FFFF, 32'h0A00_0001, 11, 12, 6, 7));
        send_flow_item(flow_rec(32'hC0A8_0101, 32'hAC15_0000, 13, 14, 8, 9));
        send_flow_item(flow_rec(32'h0100_0000, 32'hC0A8_0101, 15, 16, 10, 11));
        // local wins over an overlapping other range
        send_flow_item(flow_rec(32'h0A00_0010, 32'h0B00_0000, 17, 18, 12, 13));
        send_flow_item(flow_rec(32'h09FF_FFFF, 32'h0B00_0000, 19, 20, 14, 15));
        send_flow_item(flow_rec(32'h0A12_3456, 32'h0900_0000, '1, '1, '1, '1));
    endtask

    task automatic test_load_full_tables();
        int          i;
        logic [31:0] lo;
        logic [31:0] hi;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            make_range(lo, hi);
            send_flow_item(load_rec(CMD_LOAD_LOCAL, i[2:0], lo, hi));
            make_range(lo, hi);
            send_flow_item(load_rec(CMD_LOAD_OTHER, i[2:0], lo, hi));
        end
    endtask

    task automatic test_random_traffic(input int n_items,
                                       input logic [CNT_W-1:0] lcount,
                                       input logic [CNT_W-1:0] ocount,
                                       input int idle_pct, input int stall_pct);
        t_ifrc_in it;
        write_counts(lcount, ocount);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (n_items) begin
            random_item(it);
            send_flow_item(it);
        end
    endtask

    task automatic test_pause_until_drained(input int n_items);
        t_ifrc_in it;
        write_counts(4'd1, 4'd8);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (n_items) begin
            random_item(it);
            send_flow_item(it);
        end
        wait_drained();
        repeat (n_items) begin
            random_item(it);
            send_flow_item(it);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_LOCAL_COUNT;
        i_cfg_data  = '0;
        lcl_count   = '0;
        oth_count   = '0;
        run_totals  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_corners();
        test_load_full_tables();
        test_random_traffic(400, 4'd8, 4'd8, 0, 0);
        test_random_traffic(300, 4'd15, 4'd15, 72, 0);
        test_random_traffic(300, 4'd3, 4'd0, 0, 72);
        test_random_traffic(300, 4'd0, 4'd5, 19, 19);
        test_pause_until_drained(100);
        test_random_traffic(300, 4'd9, 4'd1, 19, 19);
        test_random_traffic(100, 4'd0, 4'd0, 0, 0);
        wait_drained();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
